@@ hw/rtl/asd_pkg.sv @@
// Shared constants and types for the archive stream decryptor.
// No dependencies; imported by asd_keygen, archive_stream_decryptor and tb_top.
package asd_pkg;

	localparam logic [31:0] WORD_MAGIC = 32'h9E37_0001;

	localparam int IN_TDATA_W  = 120;	// 113 field bits padded to whole bytes
	localparam int OUT_TDATA_W = 8;

	// bit positions of the input fields inside s_tdata
	localparam int DATA_LSB = 0;
	localparam int SEED_LSB = 8;
	localparam int OFFS_LSB = 40;
	localparam int LEN_LSB  = 48;
	localparam int WSUB_BIT = 80;
	localparam int PSIZ_LSB = 81;

	localparam logic MODE_DATA  = 1'b0;
	localparam logic MODE_START = 1'b1;

	typedef struct packed {
		logic        mode;
		logic [7:0]  data_byte;
		logic [31:0] key_seed;
		logic [7:0]  start_offset;
		logic [31:0] buffer_length;
		logic        word_subtract;
		logic [31:0] plain_size;
	} asd_item_t;

	// keystream generator control
	typedef struct packed {
		logic load;	// start transfer: reload from seed and offset
		logic step;	// data transfer: advance by one bit
	} asd_ks_ctl_t;

endpackage

@@ hw/rtl/asd_keygen.sv @@
// Keystream generator: product base register plus a running rotation count.
// Depends on asd_pkg.
module asd_keygen (
	input  logic                 clk,
	input  logic                 arst_n,
	input  asd_pkg::asd_ks_ctl_t ctl,
	input  logic [31:0]          seed,
	input  logic [5:0]           rot_init,
	output logic [7:0]           key_byte
);
	import asd_pkg::*;

	// keystream value = rotl(base_q, rot_q); the base never moves
	logic [63:0] base_q;
	logic [5:0]  rot_q;
	logic [63:0] prod;
	logic [5:0]  idx [8];

	assign prod = 64'(seed) * 64'(WORD_MAGIC);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q <= '0;
			rot_q  <= '0;
		end else if (ctl.load) begin
			base_q <= {prod[31:0], prod[63:32]};
			rot_q  <= rot_init;
		end else if (ctl.step) begin
			rot_q <= rot_q + 6'd1;
		end
	end

	// bits 39..32 of the rotated value
	always_comb begin
		for (int i = 0; i < 8; i++) begin
			idx[i]      = 6'(32 + i) - rot_q;
			key_byte[i] = base_q[idx[i]];
		end
	end

endmodule

@@ hw/rtl/archive_stream_decryptor.sv @@
// Archive stream decryptor top level: input register, XOR and word subtract, result register.
// Depends on asd_pkg and asd_keygen.
// A data byte passes from the input register through the result register to m_tdata.
// Throughput: one item per cycle, keystream and borrow included, unless the output stalls.
// Start items produce no output transfer.
// Reset (arst_n low, asynchronous) clears the keystream, word state and all valid flags.
module archive_stream_decryptor (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	// s_tdata fields, LSB up: data_byte[7:0], key_seed[39:8], start_offset[47:40],
	// buffer_length[79:48], word_subtract[80], plain_size[112:81], zero pad
	input  logic [asd_pkg::IN_TDATA_W-1:0] s_tdata,
	input  logic                           s_tuser,	// mode: 0 data, 1 start
	output logic                           m_tvalid,
	input  logic                           m_tready,
	output logic [asd_pkg::OUT_TDATA_W-1:0] m_tdata	// out_byte[7:0]
);
	import asd_pkg::*;

	asd_item_t   item_s1;
	logic        s1_valid_q;
	logic        s1_fire;
	logic        in_xfer;

	logic        out_valid_q;
	logic [7:0]  out_byte_q;

	logic [31:0] word_key_q;
	logic [1:0]  lane_q;
	logic        borrow_q;
	logic [31:0] left_q;
	logic        sub_on_q;

	asd_ks_ctl_t ks_ctl;
	logic [7:0]  key_byte;
	logic [7:0]  xored;
	logic [7:0]  kb;
	logic [8:0]  sub;
	logic [8:0]  diff;
	logic        sub_active;
	logic [7:0]  result;
	logic [1:0]  lane_nxt;

	// a start needs no output slot; a data byte needs the result register free
	assign s1_fire  = s1_valid_q && (item_s1.mode == MODE_START || !out_valid_q || m_tready);
	assign s_tready = !s1_valid_q || s1_fire;
	assign in_xfer  = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (s_tready) begin
			s1_valid_q <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			item_s1.mode          <= s_tuser;
			item_s1.data_byte     <= s_tdata[DATA_LSB +: 8];
			item_s1.key_seed      <= s_tdata[SEED_LSB +: 32];
			item_s1.start_offset  <= s_tdata[OFFS_LSB +: 8];
			item_s1.buffer_length <= s_tdata[LEN_LSB +: 32];
			item_s1.word_subtract <= s_tdata[WSUB_BIT];
			item_s1.plain_size    <= s_tdata[PSIZ_LSB +: 32];
		end
	end

	assign ks_ctl.load = s1_fire && item_s1.mode == MODE_START;
	assign ks_ctl.step = s1_fire && item_s1.mode == MODE_DATA;

	asd_keygen u_keygen (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (ks_ctl),
		.seed     (item_s1.key_seed),
		.rot_init (item_s1.start_offset[5:0]),
		.key_byte (key_byte)
	);

	always_comb begin
		xored      = item_s1.data_byte ^ key_byte;
		sub_active = sub_on_q && left_q != 32'd0;
		kb         = 8'(word_key_q >> {lane_q, 3'b000});
		sub        = {1'b0, kb} + 9'(borrow_q);
		diff       = {1'b0, xored} - sub;	// bit 8 set on underflow
		result     = sub_active ? diff[7:0] : xored;
		lane_nxt   = lane_q + 2'd1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			word_key_q <= '0;
			lane_q     <= '0;
			borrow_q   <= 1'b0;
			left_q     <= '0;
			sub_on_q   <= 1'b0;
		end else if (ks_ctl.load) begin
			word_key_q <= item_s1.plain_size ^ WORD_MAGIC;
			lane_q     <= '0;
			borrow_q   <= 1'b0;
			left_q     <= {item_s1.buffer_length[31:2], 2'b00};
			sub_on_q   <= item_s1.word_subtract;
		end else if (ks_ctl.step && sub_active) begin
			lane_q   <= lane_nxt;
			borrow_q <= (lane_nxt == 2'd0) ? 1'b0 : diff[8];
			left_q   <= left_q - 32'd1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ks_ctl.step) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ks_ctl.step) begin
			out_byte_q <= result;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_byte_q;

`ifndef SYNTH
	a_data_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		ks_ctl.step |=> out_valid_q)
		else $error("data transfer did not load the result register");

	a_lane_tracks_count: assert property (@(posedge clk) disable iff (!arst_n)
		2'(left_q[1:0] + lane_q) == 2'b00)
		else $error("byte lane out of step with remaining word bytes");

	a_no_borrow_at_word_start: assert property (@(posedge clk) disable iff (!arst_n)
		lane_q == 2'd0 |-> !borrow_q)
		else $error("borrow carried across a word boundary");

	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!s1_valid_q |-> s_tready)
		else $error("input stalled with empty input register");

	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !m_tready |=> out_valid_q && $stable(out_byte_q))
		else $error("pending result lost or overwritten");
`endif

endmodule

@@ verif/tb_top.sv @@
`timescale 1ns / 1ps
// Self-checking bench for archive_stream_decryptor: directed and random buffers, byte checks.
// Depends on asd_pkg and the RTL under hw/rtl; a class predicts each plain byte in order.
module tb_top;
	import asd_pkg::*;

	class decrypt_checker;
		logic [63:0] keystream;
		logic [31:0] word_key;
		logic [1:0]  lane;
		logic        borrow;
		logic [31:0] word_left;
		logic        sub_on;
		logic [7:0]  expected_plain[$];
		int          errors;
		int          n_items;
		int          n_starts;
		int          n_checked;
		int          n_sub_bytes;

		function new();
			keystream = '0;
			word_key = '0;
			lane = '0;
			borrow = 1'b0;
			word_left = '0;
			sub_on = 1'b0;
			errors = 0;
			n_items = 0;
			n_starts = 0;
			n_checked = 0;
			n_sub_bytes = 0;
		endfunction

		// accepted input transfer: advance the model, queue the plain byte
		function void note_transfer(asd_item_t it);
			logic [63:0] prod;
			logic [63:0] swp;
			logic [7:0]  b;
			logic [7:0]  kb;
			logic [8:0]  sub;
			int          sh;
			n_items++;
			if (it.mode == MODE_START) begin
				n_starts++;
				prod = {32'b0, it.key_seed} * {32'b0, WORD_MAGIC};
				swp = {prod[31:0], prod[63:32]};
				sh = int'(it.start_offset[5:0]);
				keystream = (sh == 0) ? swp : ((swp << sh) | (swp >> (64 - sh)));
				word_key = it.plain_size ^ WORD_MAGIC;
				lane = '0;
				borrow = 1'b0;
				word_left = {it.buffer_length[31:2], 2'b00};
				sub_on = it.word_subtract;
			end else begin
				b = it.data_byte ^ keystream[39:32];
				keystream = {keystream[62:0], keystream[63]};
				if (sub_on && word_left != 0) begin
					kb = word_key[8*lane +: 8];
					sub = {1'b0, kb} + {8'b0, borrow};
					borrow = ({1'b0, b} < sub);
					b = b - sub[7:0];
					lane = lane + 2'd1;
					if (lane == 2'd0)
						borrow = 1'b0;
					word_left = word_left - 32'd1;
					n_sub_bytes++;
				end
				expected_plain.push_back(b);
			end
		endfunction

		function void check_byte(logic [7:0] got);
			logic [7:0] want;
			if (expected_plain.size() == 0) begin
				$error("out_byte: no byte expected, got %02h", got);
				errors++;
			end else begin
				want = expected_plain.pop_front();
				n_checked++;
				if (got !== want) begin
					$error("out_byte: expected %02h, actual %02h", want, got);
					errors++;
				end
			end
		endfunction

		function int pending();
			return expected_plain.size();
		endfunction
	endclass

	logic                    clk = 1'b0;
	logic                    arst_n = 1'b0;
	logic                    s_tvalid = 1'b0;
	logic                    s_tready;
	logic [IN_TDATA_W-1:0]   s_tdata = '0;
	logic                    s_tuser = 1'b0;
	logic                    m_tvalid;
	logic                    m_tready = 1'b0;
	logic [OUT_TDATA_W-1:0]  m_tdata;

	decrypt_checker chk = new();
	bit src_idle = 1'b1;
	bit snk_idle = 1'b1;

	always #5 clk = ~clk;

	archive_stream_decryptor u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	function automatic asd_item_t rand_item();
		asd_item_t it;
		it.mode = MODE_DATA;
		it.data_byte = 8'($urandom);
		it.key_seed = $urandom;
		it.start_offset = 8'($urandom);
		it.buffer_length = $urandom;
		it.word_subtract = 1'($urandom);
		it.plain_size = $urandom;
		return it;
	endfunction

	function automatic asd_item_t start_item(logic [31:0] seed, logic [7:0] offs,
			logic [31:0] len, logic wsub, logic [31:0] psize);
		asd_item_t it;
		it = rand_item();
		it.mode = MODE_START;
		it.key_seed = seed;
		it.start_offset = offs;
		it.buffer_length = len;
		it.word_subtract = wsub;
		it.plain_size = psize;
		return it;
	endfunction

	function automatic asd_item_t data_item(logic [7:0] b);
		asd_item_t it;
		it = rand_item();
		it.data_byte = b;
		return it;
	endfunction

	task automatic send_item(asd_item_t it);
		int gap;
		gap = src_idle ? $urandom_range(0, 15) : 0;
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= it.mode;
		s_tdata <= {7'b0, it.plain_size, it.word_subtract, it.buffer_length,
			it.start_offset, it.key_seed, it.data_byte};
		do @(posedge clk); while (!s_tready);
		chk.note_transfer(it);
	endtask

	// sender idles until every predicted byte has been received
	task automatic wait_drained();
		s_tvalid <= 1'b0;
		while (chk.pending() != 0) @(posedge clk);
	endtask

	// one buffer: start then a run of bytes, sometimes past the buffer end
	task automatic send_buffer();
		logic [31:0] len;
		int          nbytes;
		len = ($urandom_range(0, 7) == 0) ? $urandom : $urandom_range(0, 40);
		send_item(start_item($urandom, 8'($urandom), len, $urandom_range(0, 3) != 0,
			$urandom));
		nbytes = (len <= 40) ? $urandom_range(0, len + 6) : $urandom_range(0, 40);
		repeat (nbytes) send_item(data_item(8'($urandom)));
	endtask

	// receive side
	initial begin
		int gap;
		wait (arst_n === 1'b1);
		forever begin
			gap = snk_idle ? $urandom_range(0, 15) : 0;
			if (gap > 0) begin
				m_tready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
			chk.check_byte(m_tdata);
		end
	end

	initial begin
		#5ms;
		$display("DONE: errors detected");
		$finish;
	end

	initial begin
		int phase;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// bytes before any start see a zero keystream
		send_item(data_item(8'h00));
		send_item(data_item(8'hFF));
		// zero seed: key bytes only, borrow out of lanes 0 and 2
		send_item(start_item(32'h0, 8'h00, 32'd8, 1'b1, 32'h0));
		send_item(data_item(8'h00));
		send_item(data_item(8'hFF));
		send_item(data_item(8'h00));
		send_item(data_item(8'hFF));
		// maximum rotation, partial trailing word, bytes past the last whole word
		send_item(start_item(32'hFFFF_FFFF, 8'hFF, 32'd7, 1'b1, 32'hFFFF_FFFF));
		repeat (6) send_item(data_item(8'($urandom)));
		// half swap, maximum length, no subtract
		send_item(start_item(32'h1234_5678, 8'h20, 32'hFFFF_FFFF, 1'b0, 32'h0));
		send_item(data_item(8'hFF));
		send_item(data_item(8'h00));
		// offset with zero low bits, zero word key
		send_item(start_item(32'hA5A5_A5A5, 8'hC0, 32'd4, 1'b1, WORD_MAGIC));
		repeat (3) send_item(data_item(8'($urandom)));
		// empty buffer with subtract enabled
		send_item(start_item($urandom, 8'h01, 32'd0, 1'b1, $urandom));
		send_item(data_item(8'($urandom)));

		phase = 0;
		while (chk.n_items < 950) begin
			wait_drained();
			src_idle = phase[0];
			snk_idle = phase[1];
			repeat ($urandom_range(3, 8)) begin
				if ($urandom_range(0, 7) != 0)
					send_buffer();
				else
					repeat ($urandom_range(1, 6)) begin
						asd_item_t it;
						it = rand_item();
						it.mode = 1'($urandom);
						send_item(it);
					end
			end
			phase++;
		end
		s_tvalid <= 1'b0;

		wait_drained();
		repeat (10) @(posedge clk);
		$display("Sent %0d transfers in %0d buffers; %0d bytes checked,",
			chk.n_items, chk.n_starts, chk.n_checked);
		$display("%0d of them word-subtracted.", chk.n_sub_bytes);
		if (chk.errors == 0 && chk.pending() == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
